@@ rtl/mqft_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the multi-queue FIFO table.
// Used by mqft_slot_table, mqft_store and multi_queue_fifo_table; no dependencies.
package mqft_pkg;

   localparam int NUM_QUEUES  = 8;
   localparam int QUEUE_DEPTH = 16;

   localparam int SLOT_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int ADDR_W = SLOT_W + PTR_W;
   localparam int STORE_DEPTH = 1 << ADDR_W;

   localparam int ID_W   = 8;
   localparam int WORD_W = 16;
   localparam int OP_W   = 3;

   typedef enum logic [OP_W-1:0] {
      OP_REGISTER  = 3'd0,
      OP_PUT       = 3'd1,
      OP_GET       = 3'd2,
      OP_RELEASE   = 3'd3,
      OP_RESET_ALL = 3'd4
   } op_type;

   // Access to the word store issued by the slot table.
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
      logic [WORD_W-1:0] wdata;
   } mem_req_type;

   // Outcome of one operation as decided by the slot table.
   typedef struct packed {
      logic ok;
      logic get;
   } tbl_rsp_type;

endpackage

@@ rtl/mqft_slot_table.sv @@
`timescale 1ns / 1ps
// Slot table: owner ids and read/write pointers of every queue, id lookup
// and pointer update. Depends on mqft_pkg.
module mqft_slot_table (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        op_valid,
   input  mqft_pkg::op_type            op,
   input  logic [mqft_pkg::ID_W-1:0]   queue_id,
   input  logic [mqft_pkg::WORD_W-1:0] data_in,
   output mqft_pkg::tbl_rsp_type       tbl_rsp,
   output mqft_pkg::mem_req_type       mem_req
);

   logic [mqft_pkg::ID_W-1:0]  owner_ff [mqft_pkg::NUM_QUEUES];
   logic [mqft_pkg::PTR_W-1:0] wptr_ff  [mqft_pkg::NUM_QUEUES];
   logic [mqft_pkg::PTR_W-1:0] rptr_ff  [mqft_pkg::NUM_QUEUES];

   logic                        free_hit;
   logic [mqft_pkg::SLOT_W-1:0] free_slot;
   logic                        id_hit;
   logic [mqft_pkg::SLOT_W-1:0] id_slot;
   logic [mqft_pkg::PTR_W-1:0]  hit_wptr;
   logic [mqft_pkg::PTR_W-1:0]  hit_rptr;
   logic                        id_nonzero;

   function automatic logic [mqft_pkg::PTR_W-1:0] advance(
      input logic [mqft_pkg::PTR_W-1:0] p);
      return (p == mqft_pkg::PTR_W'(mqft_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // Priority search: scanning downward leaves the lowest matching slot.
   always_comb begin
      free_hit  = 1'b0;
      free_slot = '0;
      id_hit    = 1'b0;
      id_slot   = '0;
      for (int i = mqft_pkg::NUM_QUEUES - 1; i >= 0; i--) begin
         if (owner_ff[i] == '0) begin
            free_hit  = 1'b1;
            free_slot = mqft_pkg::SLOT_W'(i);
         end
         if (owner_ff[i] == queue_id) begin
            id_hit  = 1'b1;
            id_slot = mqft_pkg::SLOT_W'(i);
         end
      end
   end

   assign id_nonzero = (queue_id != '0);
   assign hit_wptr   = wptr_ff[id_slot];
   assign hit_rptr   = rptr_ff[id_slot];

   always_comb begin
      tbl_rsp       = '0;
      mem_req       = '0;
      mem_req.wdata = data_in;
      case (op)
         mqft_pkg::OP_REGISTER: begin
            tbl_rsp.ok = id_nonzero && free_hit;
         end
         mqft_pkg::OP_PUT: begin
            tbl_rsp.ok    = id_nonzero && id_hit;
            mem_req.wr_en = op_valid && tbl_rsp.ok;
            mem_req.addr  = {id_slot, hit_wptr};
         end
         mqft_pkg::OP_GET: begin
            tbl_rsp.get   = 1'b1;
            tbl_rsp.ok    = id_nonzero && id_hit && (hit_rptr != hit_wptr);
            mem_req.rd_en = op_valid && tbl_rsp.ok;
            mem_req.addr  = {id_slot, hit_rptr};
         end
         mqft_pkg::OP_RELEASE: begin
            tbl_rsp.ok = id_nonzero && id_hit;
         end
         mqft_pkg::OP_RESET_ALL: begin
            tbl_rsp.ok = 1'b1;
         end
         default: begin
            tbl_rsp.ok = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mqft_pkg::NUM_QUEUES; i++) begin
            owner_ff[i] <= '0;
            wptr_ff[i]  <= '0;
            rptr_ff[i]  <= '0;
         end
      end else if (op_valid && tbl_rsp.ok) begin
         case (op)
            mqft_pkg::OP_REGISTER: begin
               owner_ff[free_slot] <= queue_id;
               wptr_ff[free_slot]  <= '0;
               rptr_ff[free_slot]  <= '0;
            end
            mqft_pkg::OP_PUT: begin
               wptr_ff[id_slot] <= advance(hit_wptr);
            end
            mqft_pkg::OP_GET: begin
               rptr_ff[id_slot] <= advance(hit_rptr);
            end
            mqft_pkg::OP_RELEASE: begin
               owner_ff[id_slot] <= '0;
               wptr_ff[id_slot]  <= '0;
               rptr_ff[id_slot]  <= '0;
            end
            mqft_pkg::OP_RESET_ALL: begin
               for (int i = 0; i < mqft_pkg::NUM_QUEUES; i++) begin
                  owner_ff[i] <= '0;
                  wptr_ff[i]  <= '0;
                  rptr_ff[i]  <= '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule

@@ rtl/mqft_store.sv @@
`timescale 1ns / 1ps
// Word store of all queues: one synchronous memory, one access per cycle,
// registered read data that holds until the next read. Depends on mqft_pkg.
module mqft_store (
   input  logic                        clock,
   input  mqft_pkg::mem_req_type       mem_req,
   output logic [mqft_pkg::WORD_W-1:0] rd_data
);

   logic [mqft_pkg::WORD_W-1:0] mem [mqft_pkg::STORE_DEPTH];
   logic [mqft_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.addr] <= mem_req.wdata;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/multi_queue_fifo_table.sv @@
`timescale 1ns / 1ps
// Multi-queue FIFO table: eight circular queues of sixteen 16-bit words, each
// owned by a nonzero 8-bit id. Depends on mqft_pkg, mqft_slot_table, mqft_store.
//
// Usage:
//   Each transfer on the req channel carries one operation: the op code on
//   req_tuser (register, put, get, release, reset all) and the queue id and
//   put word on req_tdata. Every operation yields exactly one transfer on the
//   rsp channel: the success flag on rsp_tuser and the dequeued word on
//   rsp_tdata (zero unless a get succeeded).
//   The id lookup and pointer update happen in the accept cycle; the word
//   store is a synchronous memory whose read data arrives in the next cycle,
//   and the result then lands in the output register.
//   Throughput is one operation per cycle unless the receiver stalls: an
//   operation waiting for its store read and one in the output register
//   can coexist, and the pointer table is updated at accept, so the next
//   operation sees it at once.
//   When the receiver stalls, the block keeps accepting until both the
//   read stage and the output register are full, then drops req_tready.
//   Reset frees every slot and clears all pointers at once; the store
//   contents are left undefined and no clearing pass is needed, since a get
//   only reads words put since its slot was registered.
module multi_queue_fifo_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,  // [2:0] op
   input  logic [23:0] req_tdata,  // [7:0] queue_id, [23:8] data_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [0:0]  rsp_tuser,  // [0] ok
   output logic [15:0] rsp_tdata   // [15:0] data_out
);

   logic                        req_xfer;
   mqft_pkg::op_type            op;
   mqft_pkg::tbl_rsp_type       tbl_rsp;
   mqft_pkg::mem_req_type       mem_req;
   logic [mqft_pkg::WORD_W-1:0] rd_data;

   // Read stage: the operation waiting for its store data.
   logic s1_valid_ff, s1_valid_in;
   logic s1_ok_ff;
   logic s1_get_ff;
   logic s1_move;

   // Output register.
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_ok_ff;
   logic [mqft_pkg::WORD_W-1:0] rsp_data_ff;
   logic                        rsp_free;

   assign op       = mqft_pkg::op_type'(req_tuser);
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign s1_move  = s1_valid_ff && rsp_free;

   // A new transfer is taken whenever the read stage is empty or drains now.
   assign req_tready = !s1_valid_ff || rsp_free;
   assign req_xfer   = req_tvalid && req_tready;

   mqft_slot_table u_table (
      .clock    (clock),
      .reset    (reset),
      .op_valid (req_xfer),
      .op       (op),
      .queue_id (req_tdata[7:0]),
      .data_in  (req_tdata[23:8]),
      .tbl_rsp  (tbl_rsp),
      .mem_req  (mem_req)
   );

   mqft_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_ok_ff  <= tbl_rsp.ok;
         s1_get_ff <= tbl_rsp.get;
      end
      if (s1_move) begin
         rsp_ok_ff   <= s1_ok_ff;
         rsp_data_ff <= (s1_ok_ff && s1_get_ff) ? rd_data : '0;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tuser[0] = rsp_ok_ff;
   assign rsp_tdata    = rsp_data_ff;

   // A nonzero word is only ever delivered by a successful operation.
   a_data_needs_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata != '0) |-> rsp_tuser[0])
      else $error("nonzero data_out on a refused operation");

   // With both stages full and the receiver stalled, nothing new is taken.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("transfer accepted while the result path is full");

   // Reset all always succeeds and lands in the read stage.
   a_reset_all_ok: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && op == mqft_pkg::OP_RESET_ALL) |=> (s1_valid_ff && s1_ok_ff))
      else $error("reset all not reported as successful");

   // A store read is only issued for a get the table accepted.
   a_read_is_get: assert property (@(posedge clock) disable iff (reset)
      mem_req.rd_en |-> (req_xfer && op == mqft_pkg::OP_GET && !mem_req.wr_en))
      else $error("store read outside an accepted get");

endmodule
